>>> rtl/core/msv_pkg.sv
package msv_pkg;

	// Default geometry
	localparam int PHASE_BITS_DEF      = 24;
	localparam int SINE_TABLE_BITS_DEF = 10;

	// Field and register widths
	localparam int BASE_STEP_W = 24;
	localparam int GAIN_W      = 7;
	localparam int NOTE_W      = 7;
	localparam int LEVEL_W     = 7;
	localparam int SAMPLE_W    = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int MUL_W       = 32;
	localparam int PROD_W      = 64;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_STEP = 2'd0,
		CFG_GAIN      = 2'd1,
		CFG_VEL_EN    = 2'd2
	} cfg_reg_t;

	localparam logic [BASE_STEP_W-1:0] BASE_STEP_RST = 24'd76880;
	localparam logic [GAIN_W-1:0]      GAIN_RST      = 7'd100;
	localparam logic                   VEL_EN_RST    = 1'b1;

	// MIDI status upper nibbles
	localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
	localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd127;

	// Largest sample change per tick, 0.1 of full scale
	localparam int SLEW_LIMIT = 3277;

	// Quarter-wave sine polynomial, Q30 coefficients
	localparam logic [MUL_W-1:0] POLY_A1 = 32'd1686629713;
	localparam logic [MUL_W-1:0] POLY_A3 = 32'd693598668;
	localparam logic [MUL_W-1:0] POLY_A5 = 32'd85569306;
	localparam logic [MUL_W-1:0] POLY_A7 = 32'd5026995;
	localparam logic [MUL_W-1:0] POLY_A9 = 32'd172272;

	// Scaling by level/127 * gain/100: divide by 12700 with rounding,
	// done as a multiply by a reciprocal that is exact for dividends below 2^30
	localparam longint unsigned SCALE_DIV   = 64'd12700;
	localparam int              ROUND_HALF  = 6350;
	localparam int              RECIP_SHIFT = 44;
	localparam longint unsigned RECIP_FULL  =
		((64'd1 << RECIP_SHIFT) + SCALE_DIV - 64'd1) / SCALE_DIV;
	localparam logic [MUL_W-1:0] RECIP_MUL  = RECIP_FULL[MUL_W-1:0];

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_STEP  = 4'd2,
		OP_PHASE = 4'd3,
		OP_T2    = 4'd4,
		OP_H9    = 4'd5,
		OP_H7    = 4'd6,
		OP_H5    = 4'd7,
		OP_H3    = 4'd8,
		OP_S     = 4'd9,
		OP_LG    = 4'd10,
		OP_MAG   = 4'd11,
		OP_DIV   = 4'd12,
		OP_FIN   = 4'd13
	} dp_op_t;

	// Semitone ratio, round(65536 * 2^(semi/12))
	function automatic logic [16:0] semitone_ratio(input logic [3:0] semi);
		logic [16:0] r;
		case (semi)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd69433;
			4'd2:    r = 17'd73562;
			4'd3:    r = 17'd77936;
			4'd4:    r = 17'd82570;
			4'd5:    r = 17'd87480;
			4'd6:    r = 17'd92682;
			4'd7:    r = 17'd98193;
			4'd8:    r = 17'd104032;
			4'd9:    r = 17'd110218;
			4'd10:   r = 17'd116772;
			4'd11:   r = 17'd123715;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	// Note / 12 by reciprocal, exact over 0..127
	function automatic logic [3:0] note_octave(input logic [NOTE_W-1:0] n);
		logic [12:0] p;
		p = 13'(n) * 13'd43;
		return p[12:9];
	endfunction

	// Note % 12
	function automatic logic [3:0] note_semi(input logic [NOTE_W-1:0] n);
		logic [NOTE_W-1:0] r;
		r = n - 7'(note_octave(n)) * 7'd12;
		return r[3:0];
	endfunction

endpackage

>>> rtl/core/midi_sine_voice_slew_limited.sv
// Single-voice MIDI sine oscillator with per-sample slew limit.
// Input channel (s_*): one request per audio sample tick. s_tuser flags that a
// MIDI message rides along; s_tdata carries status byte, note and velocity.
// Note-on sets note and level, note-off silences; other statuses are ignored.
// Output channel (m_*): one signed Q1.15 sample per accepted tick.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 base step, 1 gain percent, 2 velocity enable); other indexes are dropped.
// The sample is offered once its tick has passed the steps STEP, PHASE, T2, H9,
// H7, H5, H3, S, LG, MAG, DIV and FIN. A single 32x32 multiplier is shared by
// the phase step, the sine polynomial, the level scaling and the divide, so one
// tick is in flight at a time: the next is taken only after the last finishes.
// Stall: a finished sample waits in the output register; the next tick is taken
// meanwhile and runs up to its final step, where it holds until m_tready.
// Reset: phase, note, level and last sample go to zero (silent), configuration
// to its defaults; no result is pending.
module midi_sine_voice_slew_limited #(
	parameter int PHASE_BITS      = msv_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = msv_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Tick input
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,  // status_byte, note_number, velocity
	input  logic                           s_tuser,  // event_valid
	// Sample output
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,  // sample_out
	// Configuration
	input  logic                           cfg_we,
	input  logic [msv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [msv_pkg::CFG_DATA_W-1:0] cfg_data
);
	import msv_pkg::*;

	dp_op_t                     op;
	logic signed [SAMPLE_W-1:0] sample;

	msv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.op       (op)
	);

	msv_datapath #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.event_valid (s_tuser),
		.status_byte (s_tdata[7:0]),
		.note_number (s_tdata[14:8]),
		.velocity    (s_tdata[21:15]),
		.sample      (sample)
	);

	assign m_tdata = sample;

endmodule

>>> rtl/core/msv_ctrl.sv
module msv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic            m_tready,
	output logic            m_tvalid,
	output msv_pkg::dp_op_t op
);
	import msv_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE  = 13'b0000000000001,
		ST_STEP  = 13'b0000000000010,
		ST_PHASE = 13'b0000000000100,
		ST_T2    = 13'b0000000001000,
		ST_H9    = 13'b0000000010000,
		ST_H7    = 13'b0000000100000,
		ST_H5    = 13'b0000001000000,
		ST_H3    = 13'b0000010000000,
		ST_S     = 13'b0000100000000,
		ST_LG    = 13'b0001000000000,
		ST_MAG   = 13'b0010000000000,
		ST_DIV   = 13'b0100000000000,
		ST_FIN   = 13'b1000000000000
	} state_t;

	state_t state_q, state_nxt;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	// Sequence one sample through the shared multiplier
	always_comb begin
		state_nxt = state_q;
		op        = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op        = OP_LOAD;
					state_nxt = ST_STEP;
				end
			end
			ST_STEP: begin
				op        = OP_STEP;
				state_nxt = ST_PHASE;
			end
			ST_PHASE: begin
				op        = OP_PHASE;
				state_nxt = ST_T2;
			end
			ST_T2: begin
				op        = OP_T2;
				state_nxt = ST_H9;
			end
			ST_H9: begin
				op        = OP_H9;
				state_nxt = ST_H7;
			end
			ST_H7: begin
				op        = OP_H7;
				state_nxt = ST_H5;
			end
			ST_H5: begin
				op        = OP_H5;
				state_nxt = ST_H3;
			end
			ST_H3: begin
				op        = OP_H3;
				state_nxt = ST_S;
			end
			ST_S: begin
				op        = OP_S;
				state_nxt = ST_LG;
			end
			ST_LG: begin
				op        = OP_LG;
				state_nxt = ST_MAG;
			end
			ST_MAG: begin
				op        = OP_MAG;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				op        = OP_DIV;
				state_nxt = ST_FIN;
			end
			ST_FIN: begin
				// hold until the previous sample has been taken
				if (out_free) begin
					op        = OP_FIN;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Track the result request on the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/core/msv_datapath.sv
module msv_datapath #(
	parameter int PHASE_BITS      = msv_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = msv_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  msv_pkg::dp_op_t                     op,
	input  logic                                cfg_we,
	input  logic [msv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msv_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                event_valid,
	input  logic [7:0]                          status_byte,
	input  logic [msv_pkg::NOTE_W-1:0]          note_number,
	input  logic [msv_pkg::LEVEL_W-1:0]         velocity,
	output logic signed [msv_pkg::SAMPLE_W-1:0] sample
);
	import msv_pkg::*;

	localparam int QB      = SINE_TABLE_BITS - 2;
	localparam int T_SHIFT = 30 - QB;
	localparam int STEP_LO = 48 - PHASE_BITS;

	// Architectural state and configuration
	logic [BASE_STEP_W-1:0]     base_step_q;
	logic [GAIN_W-1:0]          gain_q;
	logic                       vel_en_q;
	logic [PHASE_BITS-1:0]      phase_q;
	logic [NOTE_W-1:0]          note_q;
	logic [LEVEL_W-1:0]         level_q;
	logic signed [SAMPLE_W-1:0] last_q;

	// Working registers
	logic [PROD_W-1:0] prod_q;
	logic [30:0]       t_q;
	logic [MUL_W-1:0]  t2_q;
	logic              neg_q;
	logic [14:0]       mag_q;

	logic [MUL_W-1:0]           mul_a, mul_b;
	logic [PROD_W-1:0]          product;
	logic                       mul_en;
	logic [MUL_W-1:0]           sub_term;
	logic [3:0]                 octave;
	logic [47:0]                step_full;
	logic [PHASE_BITS-1:0]      phase_nxt;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic [QB-1:0]              pos;
	logic [QB:0]                xq;
	logic [30:0]                t_nxt;
	logic [34:0]                s_rnd;
	logic [19:0]                m_full;
	logic [14:0]                mag_nxt;
	logic [16:0]                scaled;
	logic signed [18:0]         target, prev, hi_lim, lo_lim, slewed;
	logic signed [SAMPLE_W-1:0] sat;

	assign sample   = last_q;
	assign sub_term = prod_q[61:30];

	// Phase step from the product base_step * ratio, shifted by octave
	assign octave    = note_octave(note_q);
	assign step_full = {7'd0, prod_q[40:0]} << octave;
	assign phase_nxt = phase_q + step_full[47:STEP_LO];

	// Fold the table index into one quarter wave
	assign idx   = phase_nxt[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign pos   = idx[QB-1:0];
	assign xq    = idx[QB] ? (((QB+1)'(1) << QB) - {1'b0, pos}) : {1'b0, pos};
	assign t_nxt = 31'(xq) << T_SHIFT;

	// Round the Q30 sine to Q15 and cap
	assign s_rnd   = 35'(prod_q[63:30]) + 35'(16384);
	assign m_full  = s_rnd[34:15];
	assign mag_nxt = (m_full > 20'd32767) ? 15'h7fff : m_full[14:0];

	// Apply sign, slew limit and saturation
	assign scaled = prod_q[RECIP_SHIFT+16:RECIP_SHIFT];
	assign target = neg_q ? -$signed({2'b00, scaled}) : $signed({2'b00, scaled});
	assign prev   = 19'(last_q);
	assign hi_lim = prev + 19'(SLEW_LIMIT);
	assign lo_lim = prev - 19'(SLEW_LIMIT);

	always_comb begin
		slewed = target;
		if (target > hi_lim) begin
			slewed = hi_lim;
		end
		if (target < lo_lim) begin
			slewed = lo_lim;
		end
		if (slewed > 19'sd32767) begin
			sat = 16'sh7fff;
		end else if (slewed < -19'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = slewed[SAMPLE_W-1:0];
		end
	end

	// Select operands of the shared multiplier
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (op)
			OP_STEP: begin
				mul_a = 32'(base_step_q);
				mul_b = 32'(semitone_ratio(note_semi(note_q)));
			end
			OP_T2: begin
				mul_a = 32'(t_q);
				mul_b = 32'(t_q);
			end
			OP_H9: begin
				mul_a = sub_term;
				mul_b = POLY_A9;
			end
			OP_H7: begin
				mul_a = t2_q;
				mul_b = POLY_A7 - sub_term;
			end
			OP_H5: begin
				mul_a = t2_q;
				mul_b = POLY_A5 - sub_term;
			end
			OP_H3: begin
				mul_a = t2_q;
				mul_b = POLY_A3 - sub_term;
			end
			OP_S: begin
				mul_a = 32'(t_q);
				mul_b = POLY_A1 - sub_term;
			end
			OP_LG: begin
				mul_a = 32'(level_q);
				mul_b = 32'(gain_q);
			end
			OP_MAG: begin
				mul_a = 32'(mag_q);
				mul_b = 32'(prod_q[13:0]);
			end
			OP_DIV: begin
				mul_a = prod_q[31:0] + 32'(ROUND_HALF);
				mul_b = RECIP_MUL;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign product = 64'(mul_a) * 64'(mul_b);

	// Working registers
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= product;
		end
		if (op == OP_PHASE) begin
			t_q   <= t_nxt;
			neg_q <= idx[SINE_TABLE_BITS-1];
		end
		if (op == OP_H9) begin
			t2_q <= sub_term;
		end
		if (op == OP_LG) begin
			mag_q <= mag_nxt;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_step_q <= BASE_STEP_RST;
			gain_q      <= GAIN_RST;
			vel_en_q    <= VEL_EN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_BASE_STEP: base_step_q <= cfg_data[BASE_STEP_W-1:0];
				CFG_GAIN:      gain_q      <= cfg_data[GAIN_W-1:0];
				CFG_VEL_EN:    vel_en_q    <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// Voice state: note events, phase and last sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			note_q  <= '0;
			level_q <= '0;
			last_q  <= '0;
		end else begin
			if (op == OP_LOAD && event_valid) begin
				if (status_byte[7:4] == MIDI_NOTE_ON) begin
					note_q  <= note_number;
					level_q <= vel_en_q ? velocity : LEVEL_FULL;
				end else if (status_byte[7:4] == MIDI_NOTE_OFF) begin
					note_q  <= note_number;
					level_q <= '0;
				end
			end
			if (op == OP_PHASE) begin
				phase_q <= phase_nxt;
			end
			if (op == OP_FIN) begin
				last_q <= sat;
			end
		end
	end

endmodule

>>> tb/tb_midi_sine_voice_slew_limited.sv
`timescale 1ns / 100ps

module tb_midi_sine_voice_slew_limited;
	import msv_pkg::*;

	localparam int PH_W  = PHASE_BITS_DEF;
	localparam int TAB_W = SINE_TABLE_BITS_DEF;
	localparam int QTR_W = TAB_W - 2;

	// Quarter-wave sine polynomial, odd terms in Q30
	localparam longint unsigned SIN_C1 = 64'd1686629713;
	localparam longint unsigned SIN_C3 = 64'd693598668;
	localparam longint unsigned SIN_C5 = 64'd85569306;
	localparam longint unsigned SIN_C7 = 64'd5026995;
	localparam longint unsigned SIN_C9 = 64'd172272;

	localparam longint MAX_STEP_LSB = 3277;
	localparam longint unsigned GAIN_DIV = 64'd12700;

	// MIDI status bytes used by the stimulus
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_POLY_AT  = 8'hA0;
	localparam logic [7:0] ST_SYSEX    = 8'hF0;

	// Register index that maps to nothing
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 30;

	// Expected samples and the voice state that produces them
	class sample_scoreboard;
		logic [BASE_STEP_W-1:0] base_step;
		logic [GAIN_W-1:0] gain_pct;
		logic vel_en;
		logic [PH_W-1:0] phase;
		logic [NOTE_W-1:0] note;
		logic [LEVEL_W-1:0] level;
		logic signed [SAMPLE_W-1:0] last_sample;
		logic signed [SAMPLE_W-1:0] expected_samples[$];
		int mismatches;

		function new();
			base_step = BASE_STEP_RST;
			gain_pct = GAIN_RST;
			vel_en = VEL_EN_RST;
			phase = '0;
			note = '0;
			level = '0;
			last_sample = '0;
			mismatches = 0;
		endfunction

		function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BASE_STEP: base_step = data[BASE_STEP_W-1:0];
				CFG_GAIN:      gain_pct = data[GAIN_W-1:0];
				CFG_VEL_EN:    vel_en = data[0];
				default:       ;
			endcase
		endfunction

		// Update the voice for one accepted tick and queue its sample
		function void note_tick(logic ev, logic [7:0] status, logic [NOTE_W-1:0] nn,
				logic [LEVEL_W-1:0] vel);
			longint unsigned ratio, step, x, t, t2, h, s, m, scaled;
			longint target, prev;
			int unsigned octave, semi;
			logic [TAB_W-1:0] idx;
			logic [1:0] quad;

			if (ev && status[7:4] == MIDI_NOTE_ON) begin
				note = nn;
				level = vel_en ? vel : 7'd127;
			end else if (ev && status[7:4] == MIDI_NOTE_OFF) begin
				note = nn;
				level = '0;
			end

			// Advance the phase by the note's step
			octave = note / 12;
			semi = note % 12;
			case (semi)
				0:  ratio = 65536;
				1:  ratio = 69433;
				2:  ratio = 73562;
				3:  ratio = 77936;
				4:  ratio = 82570;
				5:  ratio = 87480;
				6:  ratio = 92682;
				7:  ratio = 98193;
				8:  ratio = 104032;
				9:  ratio = 110218;
				10: ratio = 116772;
				default: ratio = 123715;
			endcase
			step = ((64'(base_step) * ratio) << octave) >> (48 - PH_W);
			phase = phase + step[PH_W-1:0];

			// Sine from the quarter-wave polynomial
			idx = phase[PH_W-1 -: TAB_W];
			quad = idx[TAB_W-1 -: 2];
			x = quad[0] ? ((64'd1 << QTR_W) - 64'(idx[QTR_W-1:0])) : 64'(idx[QTR_W-1:0]);
			t = x << (30 - QTR_W);
			t2 = (t * t) >> 30;
			h = SIN_C7 - ((t2 * SIN_C9) >> 30);
			h = SIN_C5 - ((t2 * h) >> 30);
			h = SIN_C3 - ((t2 * h) >> 30);
			h = SIN_C1 - ((t2 * h) >> 30);
			s = (t * h) >> 30;
			m = (s + (64'd1 << 14)) >> 15;
			if (m > 64'd32767)
				m = 64'd32767;

			// Scale by level and gain, round half away from zero
			scaled = (m * 64'(level) * 64'(gain_pct) + GAIN_DIV / 2) / GAIN_DIV;
			target = quad[1] ? -longint'(scaled) : longint'(scaled);

			// Limit the change per sample, then saturate
			prev = longint'(last_sample);
			if (target > prev + MAX_STEP_LSB)
				target = prev + MAX_STEP_LSB;
			if (target < prev - MAX_STEP_LSB)
				target = prev - MAX_STEP_LSB;
			if (target > 32767)
				target = 32767;
			if (target < -32768)
				target = -32768;
			last_sample = target[SAMPLE_W-1:0];
			expected_samples.push_back(last_sample);
		endfunction

		function void check_sample(logic [SAMPLE_W-1:0] got);
			logic signed [SAMPLE_W-1:0] want;

			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected sample %0d", $signed(got));
			end else begin
				want = expected_samples.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample mismatch: expected %0d got %0d", want, $signed(got));
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;     // status_byte, note_number, velocity
	logic s_tuser = 1'b0;          // event_valid
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;          // sample_out
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	sample_scoreboard board = new();

	midi_sine_voice_slew_limited i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Drive ready: random stalls, steady high when stalls are off, or one long hold-off on request
	always begin
		@(negedge clk);
		if (hold_req) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
		end else if (idle_on) begin
			m_tready <= ($urandom_range(99) >= 29);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Check every accepted sample
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_sample(m_tdata);
	end

	// Offer one tick request; entered and left at a falling edge
	task automatic send_tick(logic ev, logic [7:0] status, logic [NOTE_W-1:0] nn,
			logic [LEVEL_W-1:0] vel);
		while (idle_on && $urandom_range(99) < 29) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= ev;
		s_tdata <= {2'b00, vel, nn, status};
		do
			@(posedge clk);
		while (!s_tready);
		board.note_tick(ev, status, nn, vel);
		@(negedge clk);
	endtask

	// Write one register; the caller lowers the enable after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		board.set_config(idx, data);
		@(negedge clk);
	endtask

	task automatic apply_setting(logic [BASE_STEP_W-1:0] base, logic [GAIN_W-1:0] gain,
			logic vel);
		write_reg(CFG_BASE_STEP, base);
		write_reg(CFG_GAIN, CFG_DATA_W'(gain));
		write_reg(CFG_VEL_EN, CFG_DATA_W'(vel));
		cfg_we <= 1'b0;
	endtask

	// Drop valid and wait for every queued sample
	task automatic drain;
		s_tvalid <= 1'b0;
		while (board.expected_samples.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Mostly plain ticks and note messages, with ignored statuses and stray data
	task automatic send_random(int count, int hold_at);
		int r;
		logic ev;
		logic [7:0] status;
		logic [NOTE_W-1:0] nn;
		logic [LEVEL_W-1:0] vel;

		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			nn = NOTE_W'($urandom_range(127));
			vel = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 7'd127 : 7'd0)
				: LEVEL_W'($urandom_range(127));
			status = 8'($urandom_range(255));
			ev = 1'b1;
			if (r < 45)
				ev = 1'b0;
			else if (r < 70)
				status = ST_NOTE_ON | 8'($urandom_range(15));
			else if (r < 85)
				status = ST_NOTE_OFF | 8'($urandom_range(15));
			else if (r >= 92) begin
				ev = 1'b0;
				status = ST_NOTE_ON | 8'($urandom_range(15));
			end
			if (i == hold_at)
				hold_req = 1'b1;
			send_tick(ev, status, nn, vel);
		end
		drain();
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed ticks at the reset configuration
		send_tick(1'b0, 8'h00, 7'd0, 7'd0);
		send_tick(1'b0, 8'h00, 7'd0, 7'd0);
		send_tick(1'b1, ST_NOTE_ON, 7'd69, 7'd127);
		send_tick(1'b0, 8'h00, 7'd0, 7'd0);
		send_tick(1'b0, 8'h00, 7'd0, 7'd0);
		send_tick(1'b1, 8'h9F, 7'd127, 7'd1);
		send_tick(1'b0, 8'h00, 7'd0, 7'd0);
		send_tick(1'b1, 8'h95, 7'd0, 7'd64);
		send_tick(1'b1, ST_POLY_AT, 7'd12, 7'd100);
		send_tick(1'b0, ST_NOTE_ON, 7'd100, 7'd127);
		send_tick(1'b1, ST_NOTE_OFF, 7'd60, 7'd127);
		send_tick(1'b0, 8'hFF, 7'd127, 7'd127);
		send_tick(1'b1, ST_NOTE_ON, 7'd72, 7'd0);
		send_tick(1'b1, 8'h8F, 7'd127, 7'd0);
		send_tick(1'b1, ST_SYSEX, 7'd0, 7'd127);
		send_tick(1'b1, 8'h9A, 7'd127, 7'd127);
		for (int i = 0; i < 5; i++)
			send_tick(1'b0, 8'h00, 7'd0, 7'd0);
		send_tick(1'b1, ST_NOTE_ON, 7'd45, 7'd127);
		send_tick(1'b0, 8'h00, 7'd0, 7'd0);
		drain();

		// Largest step, gain above full scale, velocity ignored
		apply_setting(24'hFFFFFF, 7'd127, 1'b0);
		send_random(250, -1);

		// Frozen phase
		apply_setting(24'h000000, 7'd100, 1'b1);
		send_random(150, -1);

		// Muted output
		apply_setting(BASE_STEP_W'($urandom_range(24'h03FFFF)), 7'd0,
			1'($urandom_range(1)));
		send_random(100, -1);

		// Back to defaults, no stalls on either side
		idle_on = 1'b0;
		apply_setting(BASE_STEP_RST, GAIN_RST, VEL_EN_RST);
		send_random(400, -1);
		idle_on = 1'b1;

		// Stray index and unused upper data bits, then a long output hold-off
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
		write_reg(CFG_BASE_STEP, 24'd120000);
		write_reg(CFG_GAIN, 24'hABCD00 | 24'd37);
		write_reg(CFG_VEL_EN, 24'hFFFFFE);
		cfg_we <= 1'b0;
		send_random(300, 40);

		// Random settings
		for (int k = 0; k < 4; k++) begin
			apply_setting(BASE_STEP_W'($urandom_range(24'h0FFFFF)),
				GAIN_W'($urandom_range(127)), 1'($urandom_range(1)));
			send_random(100, -1);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.expected_samples.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Stop a hung run
	initial begin
		#3_200_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> files.f
rtl/core/msv_pkg.sv
rtl/core/msv_ctrl.sv
rtl/core/msv_datapath.sv
rtl/core/midi_sine_voice_slew_limited.sv
tb/tb_midi_sine_voice_slew_limited.sv
